// ===== design/tfpf_pkg.sv =====
// ----------------------------------------------------------------------------
// tfpf_pkg - shared types, constants and font for the text framebuffer
// Operation codes, queue entry type, stream byte constants and the
// 27-symbol, five-column glyph table.
// ----------------------------------------------------------------------------
package tfpf_pkg;

	// Default geometry of the panel
	localparam int PANEL_WIDTH_DEF = 128;
	localparam int PAGE_COUNT_DEF  = 8;

	// Depth of the command queue between front and back (power of two)
	localparam int QDEPTH = 2;

	// Glyph geometry
	localparam int GLYPH_COLS = 5;
	localparam int CELL_COLS  = 6;
	localparam int GLYPHS     = 27;
	localparam int SLOT_W     = 5;

	// Stream layout
	localparam int         CMD_BYTES     = 4;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] BYTE_PAGE_CMD = 8'hB0;
	localparam logic [7:0] BYTE_COL_HI   = 8'h10;
	localparam logic [7:0] BYTE_DATA_CMD = 8'h40;

	// Reset value of the hidden column count
	localparam logic [1:0] HIDDEN_COLS_RST = 2'd2;

	// Operation codes of the input channel
	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_DRAW  = 2'd1,
		OP_FLUSH = 2'd2,
		OP_TICK  = 2'd3
	} op_kind_t;

	// Classified command handed from front to back
	typedef struct packed {
		op_kind_t            kind;
		logic [SLOT_W-1:0]   slot;
	} cmd_t;

	// Glyph slots with names
	localparam logic [SLOT_W-1:0] SLOT_BLANK  = 5'd0;
	localparam logic [SLOT_W-1:0] SLOT_COLON  = 5'd1;
	localparam logic [SLOT_W-1:0] SLOT_DOT    = 5'd2;
	localparam logic [SLOT_W-1:0] SLOT_DIGIT0 = 5'd3;
	localparam logic [SLOT_W-1:0] SLOT_A      = 5'd13;
	localparam logic [SLOT_W-1:0] SLOT_C      = 5'd14;
	localparam logic [SLOT_W-1:0] SLOT_D      = 5'd15;
	localparam logic [SLOT_W-1:0] SLOT_M      = 5'd16;
	localparam logic [SLOT_W-1:0] SLOT_Q      = 5'd17;
	localparam logic [SLOT_W-1:0] SLOT_V      = 5'd18;
	localparam logic [SLOT_W-1:0] SLOT_O      = 5'd19;
	localparam logic [SLOT_W-1:0] SLOT_P      = 5'd20;
	localparam logic [SLOT_W-1:0] SLOT_L      = 5'd21;
	localparam logic [SLOT_W-1:0] SLOT_R      = 5'd22;
	localparam logic [SLOT_W-1:0] SLOT_W_CH   = 5'd23;
	localparam logic [SLOT_W-1:0] SLOT_N      = 5'd24;
	localparam logic [SLOT_W-1:0] SLOT_FILLED = 5'd25;
	localparam logic [SLOT_W-1:0] SLOT_EMPTY  = 5'd26;

	// Font columns, LSB is the top pixel row
	localparam logic [7:0] FONT_ROM [GLYPHS][GLYPH_COLS] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h36, 8'h36, 8'h00, 8'h00},
		'{8'h00, 8'h40, 8'h60, 8'h00, 8'h00},
		'{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
		'{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
		'{8'h62, 8'h51, 8'h49, 8'h49, 8'h46},
		'{8'h22, 8'h49, 8'h49, 8'h49, 8'h36},
		'{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
		'{8'h2F, 8'h49, 8'h49, 8'h49, 8'h31},
		'{8'h3E, 8'h49, 8'h49, 8'h49, 8'h30},
		'{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
		'{8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
		'{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
		'{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E},
		'{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
		'{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
		'{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F},
		'{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E},
		'{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
		'{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
		'{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
		'{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
		'{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
		'{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F},
		'{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
		'{8'h0E, 8'h1F, 8'h1F, 8'h1F, 8'h0E},
		'{8'h0E, 8'h11, 8'h11, 8'h11, 8'h0E}
	};

	// Map a character code to its glyph slot; unknown codes are blank
	function automatic logic [SLOT_W-1:0] glyph_slot(input logic [7:0] code);
		logic [SLOT_W-1:0] slot;
		slot = SLOT_BLANK;
		if (code >= 8'h30 && code <= 8'h39) begin
			slot = SLOT_DIGIT0 + SLOT_W'(code - 8'h30);
		end else begin
			case (code)
				8'h3A:   slot = SLOT_COLON;
				8'h2E:   slot = SLOT_DOT;
				8'h41:   slot = SLOT_A;
				8'h43:   slot = SLOT_C;
				8'h44:   slot = SLOT_D;
				8'h4D:   slot = SLOT_M;
				8'h51:   slot = SLOT_Q;
				8'h56:   slot = SLOT_V;
				8'h4F:   slot = SLOT_O;
				8'h50:   slot = SLOT_P;
				8'h4C:   slot = SLOT_L;
				8'h52:   slot = SLOT_R;
				8'h57:   slot = SLOT_W_CH;
				8'h4E:   slot = SLOT_N;
				8'h01:   slot = SLOT_FILLED;
				8'h02:   slot = SLOT_EMPTY;
				default: slot = SLOT_BLANK;
			endcase
		end
		return slot;
	endfunction

endpackage

// ===== design/tfpf_ifs.sv =====
// ----------------------------------------------------------------------------
// tfpf_ifs - channel interfaces of the text framebuffer
// Valid/ready request channel and byte stream channel.
// ----------------------------------------------------------------------------
interface tfpf_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] char_code;
	logic       new_text;
	logic [6:0] column;
	logic [2:0] page_row;

	modport source (
		output valid, operation, char_code, new_text, column, page_row,
		input  ready
	);
	modport sink (
		input  valid, operation, char_code, new_text, column, page_row,
		output ready
	);
endinterface

interface tfpf_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       transfer_start;
	logic       transfer_end;
	logic       frame_done;

	modport source (
		output valid, tx_byte, transfer_start, transfer_end, frame_done,
		input  ready
	);
	modport sink (
		input  valid, tx_byte, transfer_start, transfer_end, frame_done,
		output ready
	);
endinterface

// ===== design/text_framebuffer_page_flusher_top.sv =====
// ----------------------------------------------------------------------------
// text_framebuffer_page_flusher_top - page-mode text framebuffer with flush
// Top level: request intake, command queue and execution back end.
// ----------------------------------------------------------------------------
// Requests are accepted into a two-entry command queue and run one at a time
// by a back end that owns the single write port and single read port of the
// PANEL_WIDTH x PAGE_COUNT byte framebuffer. A start flush resets the flush
// position at dispatch. A tick decodes the position and reads the memory at
// dispatch, then loads the output register, and it holds there while the
// output register still carries a byte the receiver has not taken; a tick
// with no flush active produces nothing. A draw is dispatched, then writes
// the framebuffer once per column for five glyph columns and the blank
// column. A clear zeroes all PANEL_WIDTH*PAGE_COUNT bytes, one byte zeroed
// per cycle; the same pass runs after reset, during which requests are still
// accepted into the queue but not executed. A character that does not fit
// is absorbed by the intake and never reaches the back end. hidden_columns
// is to be written through cfg_we/cfg_wdata by the user only while no work
// is pending; the block itself does not enforce this.
module text_framebuffer_page_flusher_top #(
	parameter int PANEL_WIDTH = tfpf_pkg::PANEL_WIDTH_DEF,
	parameter int PAGE_COUNT  = tfpf_pkg::PAGE_COUNT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tfpf_req_if.sink      req,
	tfpf_stream_if.source stream,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_wdata
);
	localparam int AW = $clog2(PANEL_WIDTH * PAGE_COUNT);
	localparam int QW = $bits(tfpf_pkg::cmd_t) + AW;

	logic                 push;
	tfpf_pkg::cmd_t       push_cmd;
	logic [AW-1:0]        push_base;
	logic                 full;
	logic                 pop;
	logic                 empty;
	logic [QW-1:0]        head_data;
	tfpf_pkg::cmd_t       head_cmd;
	logic [AW-1:0]        head_base;

	// Intake
	tfpf_front #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PAGE_COUNT  (PAGE_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.push      (push),
		.push_cmd  (push_cmd),
		.push_base (push_base),
		.full      (full)
	);

	// Command queue
	tfpf_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cmd, push_base}),
		.full      (full),
		.pop       (pop),
		.head_data (head_data),
		.empty     (empty)
	);

	assign head_cmd  = tfpf_pkg::cmd_t'(head_data[QW-1:AW]);
	assign head_base = head_data[AW-1:0];

	// Execution
	tfpf_back #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PAGE_COUNT  (PAGE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.empty     (empty),
		.head_cmd  (head_cmd),
		.head_base (head_base),
		.pop       (pop),
		.stream    (stream)
	);

endmodule

// ===== design/tfpf_front.sv =====
// ----------------------------------------------------------------------------
// tfpf_front - request intake and classification
// Accepts requests, owns the draw cursor, drops characters that do not fit
// and pushes classified commands into the queue.
// ----------------------------------------------------------------------------
module tfpf_front #(
	parameter int PANEL_WIDTH = tfpf_pkg::PANEL_WIDTH_DEF,
	parameter int PAGE_COUNT  = tfpf_pkg::PAGE_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tfpf_req_if.sink             req,
	output logic                 push,
	output tfpf_pkg::cmd_t       push_cmd,
	output logic [$clog2(PANEL_WIDTH*PAGE_COUNT)-1:0] push_base,
	input  logic                 full
);
	localparam int SIZE    = PANEL_WIDTH * PAGE_COUNT;
	localparam int AW      = $clog2(SIZE);
	localparam int RUN_MAX = 7 * PANEL_WIDTH + 127;
	localparam int CUR_MAX = (RUN_MAX > SIZE) ? RUN_MAX : SIZE;
	localparam int CW      = $clog2(CUR_MAX + 1);

	logic [CW-1:0] cursor_q;
	logic [CW-1:0] cur;
	logic          fits;
	logic          accept;
	logic          is_draw;

	assign req.ready = !full;
	assign accept    = req.valid && !full;
	assign is_draw   = tfpf_pkg::op_kind_t'(req.operation) == tfpf_pkg::OP_DRAW;

	// Cursor for this character, reloaded at the start of a text run
	always_comb begin
		if (req.new_text) begin
			cur = CW'(req.page_row) * CW'(PANEL_WIDTH) + CW'(req.column);
		end else begin
			cur = cursor_q;
		end
		fits = ({1'b0, cur} + (CW+1)'(tfpf_pkg::GLYPH_COLS)) < (CW+1)'(SIZE);
	end

	// Classified command; a character that does not fit is absorbed here
	assign push          = accept && !(is_draw && !fits);
	assign push_cmd.kind = tfpf_pkg::op_kind_t'(req.operation);
	assign push_cmd.slot = tfpf_pkg::glyph_slot(req.char_code);
	assign push_base     = AW'(cur);

	// Draw cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (accept && is_draw) begin
			if (fits) begin
				cursor_q <= cur + CW'(tfpf_pkg::CELL_COLS);
			end else begin
				cursor_q <= cur;
			end
		end
	end

endmodule

// ===== design/tfpf_queue.sv =====
// ----------------------------------------------------------------------------
// tfpf_queue - command queue between front and back
// Small register FIFO; lets intake and execution stall independently.
// ----------------------------------------------------------------------------
module tfpf_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             empty
);
	localparam int QPW = $clog2(tfpf_pkg::QDEPTH);

	logic [WIDTH-1:0] entry_q [tfpf_pkg::QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QPW:0]     count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == (QPW+1)'(tfpf_pkg::QDEPTH);
	assign empty     = count_q == '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_data = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level; depth is a power of two so pointers wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/tfpf_back.sv =====
// ----------------------------------------------------------------------------
// tfpf_back - command execution, framebuffer and flush sequencer
// Runs clears and draws on the framebuffer (one write port, one read port),
// keeps the flush position and produces stream bytes into an output register.
// ----------------------------------------------------------------------------
module tfpf_back #(
	parameter int PANEL_WIDTH = tfpf_pkg::PANEL_WIDTH_DEF,
	parameter int PAGE_COUNT  = tfpf_pkg::PAGE_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_wdata,
	input  logic                 empty,
	input  tfpf_pkg::cmd_t       head_cmd,
	input  logic [$clog2(PANEL_WIDTH*PAGE_COUNT)-1:0] head_base,
	output logic                 pop,
	tfpf_stream_if.source        stream
);
	localparam int SIZE = PANEL_WIDTH * PAGE_COUNT;
	localparam int AW   = $clog2(SIZE);
	localparam int BW   = $clog2(PANEL_WIDTH + 8);
	localparam int PGW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

	typedef enum logic [3:0] {
		ST_SWEEP = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_DRAW  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [AW-1:0]              sweep_q;
	logic [AW-1:0]              base_q;
	logic [tfpf_pkg::SLOT_W-1:0] slot_q;
	logic [2:0]                 col_q;
	logic [1:0]                 hidden_q;
	logic                       active_q;
	logic [PGW-1:0]             page_q;
	logic [BW-1:0]              pos_q;

	// Framebuffer
	logic [7:0]    mem_q [SIZE];
	logic [7:0]    rd_data_q;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	// Tick decode
	logic [BW-1:0] data_first;
	logic [BW-1:0] idx;
	logic [7:0]    t_byte;
	logic          t_start;
	logic          t_end;
	logic          t_mem;
	logic          page_over;
	logic          t_frame;

	// Tick stage and output register
	logic [7:0] byte_s1;
	logic       mem_s1;
	logic       start_s1;
	logic       end_s1;
	logic       frame_s1;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_start_q;
	logic       out_end_q;
	logic       out_frame_q;
	logic       out_free;

	logic dispatch;

	assign dispatch = (state_q == ST_IDLE) && !empty;
	assign pop      = dispatch;
	assign out_free = !out_valid_q || stream.ready;

	// Layout of the byte at the current flush position
	always_comb begin
		data_first = BW'(tfpf_pkg::CMD_BYTES + 1) + BW'(hidden_q);
		idx        = pos_q - data_first;
		t_byte     = tfpf_pkg::BYTE_ZERO;
		t_start    = 1'b0;
		t_end      = 1'b0;
		t_mem      = 1'b0;
		page_over  = 1'b0;
		if (pos_q < BW'(tfpf_pkg::CMD_BYTES)) begin
			if (pos_q == BW'(1)) begin
				t_byte = tfpf_pkg::BYTE_PAGE_CMD + 8'(page_q);
			end else if (pos_q == BW'(3)) begin
				t_byte = tfpf_pkg::BYTE_COL_HI;
			end
			t_start = pos_q == '0;
			t_end   = pos_q == BW'(tfpf_pkg::CMD_BYTES - 1);
		end else if (pos_q == BW'(tfpf_pkg::CMD_BYTES)) begin
			t_byte  = tfpf_pkg::BYTE_DATA_CMD;
			t_start = 1'b1;
		end else if (pos_q >= data_first) begin
			t_mem     = idx < BW'(PANEL_WIDTH);
			page_over = idx >= BW'(PANEL_WIDTH - 1);
			t_end     = page_over;
		end
		t_frame = page_over && (page_q == PGW'(PAGE_COUNT - 1));
	end

	// Framebuffer port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sweep_q;
		wr_data = tfpf_pkg::BYTE_ZERO;
		case (state_q)
			ST_SWEEP: begin
				wr_en = 1'b1;
			end
			ST_DRAW: begin
				wr_en   = 1'b1;
				wr_addr = base_q + AW'(col_q);
				if (col_q < 3'(tfpf_pkg::GLYPH_COLS)) begin
					wr_data = tfpf_pkg::FONT_ROM[slot_q][col_q];
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		rd_en   = dispatch && head_cmd.kind == tfpf_pkg::OP_TICK && active_q;
		rd_addr = AW'(page_q) * AW'(PANEL_WIDTH) + AW'(idx);
	end

	// Framebuffer storage, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Tick stage payload
	always_ff @(posedge clk) begin
		if (rd_en) begin
			byte_s1  <= t_byte;
			mem_s1   <= t_mem;
			start_s1 <= t_start;
			end_s1   <= t_end;
			frame_s1 <= t_frame;
		end
	end

	// Draw payload
	always_ff @(posedge clk) begin
		if (dispatch && head_cmd.kind == tfpf_pkg::OP_DRAW) begin
			base_q <= head_base;
			slot_q <= head_cmd.slot;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidden_q <= tfpf_pkg::HIDDEN_COLS_RST;
		end else if (cfg_we) begin
			hidden_q <= cfg_wdata;
		end
	end

	// Sequencer and flush position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_SWEEP;
			sweep_q  <= '0;
			col_q    <= '0;
			active_q <= 1'b0;
			page_q   <= '0;
			pos_q    <= '0;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!empty) begin
						case (head_cmd.kind)
							tfpf_pkg::OP_CLEAR: begin
								sweep_q <= '0;
								state_q <= ST_SWEEP;
							end
							tfpf_pkg::OP_DRAW: begin
								col_q   <= '0;
								state_q <= ST_DRAW;
							end
							tfpf_pkg::OP_FLUSH: begin
								active_q <= 1'b1;
								page_q   <= '0;
								pos_q    <= '0;
							end
							default: begin
								if (active_q) begin
									state_q <= ST_EMIT;
									if (page_over) begin
										pos_q <= '0;
										if (t_frame) begin
											active_q <= 1'b0;
											page_q   <= '0;
										end else begin
											page_q <= page_q + 1'b1;
										end
									end else begin
										pos_q <= pos_q + 1'b1;
									end
								end
							end
						endcase
					end
				end
				ST_DRAW: begin
					col_q <= col_q + 1'b1;
					if (col_q == 3'(tfpf_pkg::CELL_COLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_byte_q  <= mem_s1 ? rd_data_q : byte_s1;
			out_start_q <= start_s1;
			out_end_q   <= end_s1;
			out_frame_q <= frame_s1;
		end
	end

	assign stream.valid          = out_valid_q;
	assign stream.tx_byte        = out_byte_q;
	assign stream.transfer_start = out_start_q;
	assign stream.transfer_end   = out_end_q;
	assign stream.frame_done     = out_frame_q;

	// Framebuffer is written only by the sweep or a draw
	a_wr_owner: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_SWEEP || state_q == ST_DRAW))
		else $error("framebuffer write outside sweep or draw");

	// Queue is drained only between commands
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_IDLE && !empty)
		else $error("queue pop while busy");

	// A finished frame always closes a data transfer
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_frame_q) |-> (out_end_q && !out_start_q))
		else $error("frame_done without transfer_end");

	// Flush ends with the sequencer back at the first page
	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		(dispatch && rd_en && t_frame) |=> (!active_q && page_q == '0 && pos_q == '0))
		else $error("flush state not cleared after last page");

	// A draw never runs past its blank column
	a_draw_cols: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAW |-> col_q < 3'(tfpf_pkg::CELL_COLS))
		else $error("draw column counter overrun");

endmodule
